[sv/alc_pkg.sv]
// ----------------------------------------------------------------------------
// alc_pkg: shared types and constants for the line/cylinder clipper
// Line kind codes, register indexes, reset values of the configuration
// registers and the control flags that travel down the pipeline.
// ----------------------------------------------------------------------------
package alc_pkg;

    // line direction codes
    localparam logic [1:0] KIND_Z = 2'd0;
    localparam logic [1:0] KIND_Y = 2'd1;
    localparam logic [1:0] KIND_X = 2'd2;

    // configuration register indexes
    localparam logic [0:0] REG_RADIUS      = 1'b0;
    localparam logic [0:0] REG_HALF_HEIGHT = 1'b1;

    // reset values, Q8.8: radius 3.0, half-height 5.0
    localparam int RADIUS_RESET      = 768;
    localparam int HALF_HEIGHT_RESET = 1280;

    // per-line control flags carried alongside the data
    typedef struct packed {
        logic hit;   // line crosses the cylinder
        logic is_z;  // line runs along Z: extent is the half-height
    } line_ctl_t;

endpackage

[sv/alc_prep.sv]
// ----------------------------------------------------------------------------
// alc_prep: front end of the clipper
// Three register stages: coordinate magnitudes, squares and range checks,
// then the radial test and the radicand for the half-extent root.
// ----------------------------------------------------------------------------
module alc_prep #(
    parameter int COORD_WIDTH = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            up_valid,
    output logic                            up_ready,
    input  logic [1:0]                      kind,
    input  logic signed [COORD_WIDTH-1:0]   coord_a,
    input  logic signed [COORD_WIDTH-1:0]   coord_b,
    input  logic [COORD_WIDTH-2:0]          radius,
    input  logic [COORD_WIDTH-2:0]          half_height,
    output logic                            dn_valid,
    input  logic                            dn_ready,
    output alc_pkg::line_ctl_t              dn_ctl,
    output logic [2*COORD_WIDTH-3:0]        dn_num
);

    localparam int CW = COORD_WIDTH;

    logic rdy1;
    logic rdy2;
    logic rdy3;

    // stage 1: magnitudes
    logic              v1_reg;
    logic              is_z1_reg;
    logic              is_axis1_reg;
    logic [CW-1:0]     ma1_reg;
    logic [CW-1:0]     mb1_reg;
    logic [CW-1:0]     ma1_next;
    logic [CW-1:0]     mb1_next;

    // stage 2: squares and range checks
    logic              v2_reg;
    logic              is_z2_reg;
    logic              is_axis2_reg;
    logic              ma_ok2_reg;
    logic              mb_ok2_reg;
    logic [2*CW-1:0]   sqa2_reg;
    logic [2*CW-1:0]   sqb2_reg;
    logic [2*CW-3:0]   r2sq2_reg;
    logic [2*CW-1:0]   sqa2_next;
    logic [2*CW-1:0]   sqb2_next;
    logic [2*CW-3:0]   r2sq2_next;

    // stage 3: radial test and radicand
    logic                 v3_reg;
    alc_pkg::line_ctl_t   ctl3_reg;
    alc_pkg::line_ctl_t   ctl3_next;
    logic [2*CW-3:0]      num3_reg;
    logic [2*CW-3:0]      num3_next;
    logic [2*CW:0]        sum_sq;

    assign rdy3     = !v3_reg || dn_ready;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign up_ready = rdy1;

    always_comb
    begin
        ma1_next = coord_a[CW-1] ? (~coord_a + 1'b1) : coord_a;
        mb1_next = coord_b[CW-1] ? (~coord_b + 1'b1) : coord_b;
    end

    always_comb
    begin
        sqa2_next  = ma1_reg * ma1_reg;
        sqb2_next  = mb1_reg * mb1_reg;
        r2sq2_next = radius * radius;
    end

    always_comb
    begin
        sum_sq          = {1'b0, sqa2_reg} + {1'b0, sqb2_reg};
        // only meaningful when ma <= radius, which the hit flag demands
        num3_next       = r2sq2_reg - sqa2_reg[2*CW-3:0];
        ctl3_next.is_z  = is_z2_reg;
        ctl3_next.hit   = is_z2_reg ? (sum_sq <= {3'b000, r2sq2_reg})
                                    : (is_axis2_reg && ma_ok2_reg && mb_ok2_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
            begin
                v1_reg <= up_valid;
            end
            if (rdy2)
            begin
                v2_reg <= v1_reg;
            end
            if (rdy3)
            begin
                v3_reg <= v2_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy1)
        begin
            is_z1_reg    <= (kind == alc_pkg::KIND_Z);
            is_axis1_reg <= (kind == alc_pkg::KIND_Y) || (kind == alc_pkg::KIND_X);
            ma1_reg      <= ma1_next;
            mb1_reg      <= mb1_next;
        end
        if (rdy2)
        begin
            is_z2_reg    <= is_z1_reg;
            is_axis2_reg <= is_axis1_reg;
            ma_ok2_reg   <= (ma1_reg <= {1'b0, radius});
            mb_ok2_reg   <= (mb1_reg <= {1'b0, half_height});
            sqa2_reg     <= sqa2_next;
            sqb2_reg     <= sqb2_next;
            r2sq2_reg    <= r2sq2_next;
        end
        if (rdy3)
        begin
            ctl3_reg <= ctl3_next;
            num3_reg <= num3_next;
        end
    end

    assign dn_valid = v3_reg;
    assign dn_ctl   = ctl3_reg;
    assign dn_num   = num3_reg;

endmodule

[sv/alc_sqrt_stage.sv]
// ----------------------------------------------------------------------------
// alc_sqrt_stage: one digit of the restoring integer square root
// Brings down the next two radicand bits, tries root*4+1 against the partial
// remainder and settles one root bit, then registers the result.
// ----------------------------------------------------------------------------
module alc_sqrt_stage #(
    parameter int ROOT_WIDTH = 15
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         up_valid,
    output logic                         up_ready,
    input  alc_pkg::line_ctl_t           up_ctl,
    input  logic [ROOT_WIDTH+1:0]        up_rem,
    input  logic [ROOT_WIDTH-1:0]        up_root,
    input  logic [2*ROOT_WIDTH-1:0]      up_num,
    output logic                         dn_valid,
    input  logic                         dn_ready,
    output alc_pkg::line_ctl_t           dn_ctl,
    output logic [ROOT_WIDTH+1:0]        dn_rem,
    output logic [ROOT_WIDTH-1:0]        dn_root,
    output logic [2*ROOT_WIDTH-1:0]      dn_num
);

    localparam int RW = ROOT_WIDTH;

    logic                 valid_reg;
    alc_pkg::line_ctl_t   ctl_reg;
    logic [RW+1:0]        rem_reg;
    logic [RW+1:0]        rem_next;
    logic [RW-1:0]        root_reg;
    logic [RW-1:0]        root_next;
    logic [2*RW-1:0]      num_reg;
    logic [RW+1:0]        rem_shift;
    logic [RW+1:0]        trial;
    logic                 rdy;

    assign rdy      = !valid_reg || dn_ready;
    assign up_ready = rdy;

    always_comb
    begin
        rem_shift = {up_rem[RW-1:0], up_num[2*RW-1:2*RW-2]};
        trial     = {up_root, 2'b01};
        if (rem_shift >= trial)
        begin
            rem_next  = rem_shift - trial;
            root_next = {up_root[RW-2:0], 1'b1};
        end
        else
        begin
            rem_next  = rem_shift;
            root_next = {up_root[RW-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (rdy)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy)
        begin
            ctl_reg  <= up_ctl;
            rem_reg  <= rem_next;
            root_reg <= root_next;
            num_reg  <= {up_num[2*RW-3:0], 2'b00};
        end
    end

    assign dn_valid = valid_reg;
    assign dn_ctl   = ctl_reg;
    assign dn_rem   = rem_reg;
    assign dn_root  = root_reg;
    assign dn_num   = num_reg;

endmodule

[sv/axis_line_cylinder_clip.sv]
// ----------------------------------------------------------------------------
// axis_line_cylinder_clip: clips an axis-aligned line against a Z cylinder
// Each square-root digit has its own stage, after the prep stages.
// Throughput: one line per cycle while the output is not stalled.
// Stages advance independently, so bubbles close up behind a stalled output.
// Reset clears every valid bit and loads radius 3.0 and half-height 5.0.
// ----------------------------------------------------------------------------
module axis_line_cylinder_clip #(
    parameter int COORD_WIDTH = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_wr_en,
    input  logic [0:0]                      cfg_index,
    input  logic [COORD_WIDTH-2:0]          cfg_data,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [1:0]                      kind,
    input  logic signed [COORD_WIDTH-1:0]   coord_a,
    input  logic signed [COORD_WIDTH-1:0]   coord_b,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic                            valid_res,
    output logic signed [COORD_WIDTH-1:0]   seg_start,
    output logic [COORD_WIDTH-1:0]          seg_length
);

    localparam int CW = COORD_WIDTH;
    localparam int RW = COORD_WIDTH - 1;

    logic [CW-2:0]        radius_reg;
    logic [CW-2:0]        half_height_reg;

    logic                 in_ready;
    logic                 st_valid [0:RW];
    logic                 st_ready [0:RW];
    alc_pkg::line_ctl_t   st_ctl   [0:RW];
    logic [RW+1:0]        st_rem   [0:RW];
    logic [RW-1:0]        st_root  [0:RW];
    logic [2*RW-1:0]      st_num   [0:RW];

    logic                 out_valid_reg;
    logic                 valid_res_reg;
    logic [CW-1:0]        seg_start_reg;
    logic [CW-1:0]        seg_length_reg;
    logic [CW-1:0]        ext;
    logic [CW-1:0]        seg_start_next;
    logic [CW-1:0]        seg_length_next;
    logic                 out_ready;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg      <= (CW-1)'(alc_pkg::RADIUS_RESET);
            half_height_reg <= (CW-1)'(alc_pkg::HALF_HEIGHT_RESET);
        end
        else if (cfg_wr_en)
        begin
            if (cfg_index == alc_pkg::REG_RADIUS)
            begin
                radius_reg <= cfg_data;
            end
            else if (cfg_index == alc_pkg::REG_HALF_HEIGHT)
            begin
                half_height_reg <= cfg_data;
            end
        end
    end

    assign in_stall = !in_ready;

    alc_prep #(
        .COORD_WIDTH (CW)
    ) u_prep (
        .clk         (clk),
        .rst_n       (rst_n),
        .up_valid    (in_valid),
        .up_ready    (in_ready),
        .kind        (kind),
        .coord_a     (coord_a),
        .coord_b     (coord_b),
        .radius      (radius_reg),
        .half_height (half_height_reg),
        .dn_valid    (st_valid[0]),
        .dn_ready    (st_ready[0]),
        .dn_ctl      (st_ctl[0]),
        .dn_num      (st_num[0])
    );

    assign st_rem[0]  = '0;
    assign st_root[0] = '0;

    // one root digit per stage, most significant first
    for (genvar k = 0; k < RW; k++)
    begin : g_sqrt
        alc_sqrt_stage #(
            .ROOT_WIDTH (RW)
        ) u_stage (
            .clk      (clk),
            .rst_n    (rst_n),
            .up_valid (st_valid[k]),
            .up_ready (st_ready[k]),
            .up_ctl   (st_ctl[k]),
            .up_rem   (st_rem[k]),
            .up_root  (st_root[k]),
            .up_num   (st_num[k]),
            .dn_valid (st_valid[k+1]),
            .dn_ready (st_ready[k+1]),
            .dn_ctl   (st_ctl[k+1]),
            .dn_rem   (st_rem[k+1]),
            .dn_root  (st_root[k+1]),
            .dn_num   (st_num[k+1])
        );
    end

    // output register
    assign out_ready     = !out_valid_reg || !out_stall;
    assign st_ready[RW]  = out_ready;

    always_comb
    begin
        ext = st_ctl[RW].is_z ? {1'b0, half_height_reg} : {1'b0, st_root[RW]};
        if (st_ctl[RW].hit)
        begin
            seg_start_next  = ~ext + 1'b1;
            seg_length_next = {ext[CW-2:0], 1'b0};
        end
        else
        begin
            seg_start_next  = '0;
            seg_length_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_ready)
        begin
            out_valid_reg <= st_valid[RW];
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_ready)
        begin
            valid_res_reg  <= st_ctl[RW].hit;
            seg_start_reg  <= seg_start_next;
            seg_length_reg <= seg_length_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign valid_res  = valid_res_reg;
    assign seg_start  = seg_start_reg;
    assign seg_length = seg_length_reg;

    // an empty output register lets the whole pipeline advance
    a_no_stall_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> !in_stall)
        else $error("input stalled while output register empty");

    // a miss carries a zero segment
    a_miss_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !valid_res) |-> (seg_start == '0 && seg_length == '0))
        else $error("non-zero segment on a miss");

    // the segment is centred on the origin
    a_centred: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && valid_res) |->
            ((CW'($unsigned(seg_start)) + (seg_length >> 1)) == CW'(0)))
        else $error("segment start is not minus half the length");

    // the half-extent root never exceeds the radius
    a_root_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (st_valid[RW] && st_ctl[RW].hit && !st_ctl[RW].is_z) |->
            (st_root[RW] <= radius_reg))
        else $error("half-extent larger than radius");

endmodule
